[rtl/core/crast_pkg.sv]
`default_nettype none

package crast_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned SqW    = 24;

  localparam logic [DimW-1:0] MaxDim = 13'd4096;

  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  localparam logic RegCanvasWidth  = 1'b0;
  localparam logic RegCanvasHeight = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadX     = 2'd1;
  localparam logic [1:0] StBadY     = 2'd2;
  localparam logic [1:0] StNoCircle = 2'd3;

  // quadrant order of the four spans of one step
  localparam logic [1:0] QuadPosPos = 2'd0;
  localparam logic [1:0] QuadNegPos = 2'd1;
  localparam logic [1:0] QuadNegNeg = 2'd2;
  localparam logic [1:0] QuadPosNeg = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] radius;
    logic              filled;
    logic [7:0]        color_red;
    logic [7:0]        color_green;
    logic [7:0]        color_blue;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CoordW-1:0] span_column;
    logic [CoordW-1:0] row_first;
    logic [CoordW-1:0] row_last;
    logic              visible;
    logic [7:0]        pixel_red;
    logic [7:0]        pixel_green;
    logic [7:0]        pixel_blue;
    logic              last_of_step;
    logic              drawing_done;
  } out_word_t;

  typedef struct packed {
    logic [CoordW-1:0] span_column;
    logic [CoordW-1:0] row_first;
    logic [CoordW-1:0] row_last;
    logic              visible;
  } span_t;

  function automatic logic [DimW-1:0] dim_clamp(input logic [DimW-1:0] reg_val);
    dim_clamp = (reg_val > MaxDim) ? MaxDim : reg_val;
  endfunction

endpackage

`default_nettype wire

[rtl/core/crast_isqrt.sv]
`default_nettype none

module crast_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [crast_pkg::CoordW-1:0] radius_i,
  input  wire logic [crast_pkg::DimW-1:0]   offset_i,
  output logic                            done_o,
  output logic [crast_pkg::CoordW-1:0]    root_o
);
  import crast_pkg::*;

  localparam logic [1:0] SqIdle = 2'd0;
  localparam logic [1:0] SqMulR = 2'd1;
  localparam logic [1:0] SqMulX = 2'd2;
  localparam logic [1:0] SqRoot = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [3:0]        iter_q, iter_d;
  logic              done_q, done_d;
  logic [SqW-1:0]    sq_q, sq_d;
  logic [SqW-1:0]    v_q, v_d;
  logic [SqW-1:0]    res_q, res_d;
  logic [CoordW-1:0] mul_a;
  logic [SqW-1:0]    prod;
  logic [SqW-1:0]    bit_w;
  logic [SqW:0]      trial;
  logic              in_range;

  assign in_range = offset_i <= {1'b0, radius_i};
  assign mul_a    = (state_q == SqMulR) ? radius_i : offset_i[CoordW-1:0];
  assign prod     = SqW'(mul_a) * SqW'(mul_a);
  assign bit_w    = SqW'(1) << {iter_q, 1'b0};
  assign trial    = {1'b0, res_q} + {1'b0, bit_w};

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    done_d  = 1'b0;
    sq_d    = sq_q;
    v_d     = v_q;
    res_d   = res_q;
    unique case (state_q)
      SqIdle: begin
        if (start_i) begin
          state_d = SqMulR;
        end
      end
      SqMulR: begin
        sq_d    = prod;
        state_d = SqMulX;
      end
      SqMulX: begin
        v_d     = in_range ? (sq_q - prod) : '0;
        res_d   = '0;
        iter_d  = 4'd11;
        state_d = SqRoot;
      end
      SqRoot: begin
        if ({1'b0, v_q} >= trial) begin
          v_d   = v_q - trial[SqW-1:0];
          res_d = (res_q >> 1) + bit_w;
        end else begin
          res_d = res_q >> 1;
        end
        iter_d = iter_q - 4'd1;
        if (iter_q == 4'd0) begin
          done_d  = 1'b1;
          state_d = SqIdle;
        end
      end
      default: state_d = SqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    sq_q   <= sq_d;
    v_q    <= v_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[CoordW-1:0];

endmodule

`default_nettype wire

[rtl/core/crast_span.sv]
`default_nettype none

module crast_span (
  input  wire logic [crast_pkg::CoordW-1:0] center_x_i,
  input  wire logic [crast_pkg::CoordW-1:0] center_y_i,
  input  wire logic [crast_pkg::DimW-1:0]   offset_i,
  input  wire logic [crast_pkg::CoordW-1:0] near_i,
  input  wire logic [crast_pkg::CoordW-1:0] far_i,
  input  wire logic [1:0]                   quad_i,
  input  wire logic [crast_pkg::DimW-1:0]   width_i,
  input  wire logic [crast_pkg::DimW-1:0]   height_i,
  output crast_pkg::span_t                  span_o
);
  import crast_pkg::*;

  localparam int unsigned SW = DimW + 2;

  logic signed [SW-1:0] cx, cy, xo, a, b, w, h;
  logic signed [SW-1:0] col, lo, hi, lo_c, hi_c;
  logic                 pos_x, pos_y, vis;

  assign cx = $signed(SW'(center_x_i));
  assign cy = $signed(SW'(center_y_i));
  assign xo = $signed(SW'(offset_i));
  assign a  = $signed(SW'(near_i));
  assign b  = $signed(SW'(far_i));
  assign w  = $signed(SW'(width_i));
  assign h  = $signed(SW'(height_i));

  assign pos_x = (quad_i == QuadPosPos) || (quad_i == QuadPosNeg);
  assign pos_y = (quad_i == QuadPosPos) || (quad_i == QuadNegPos);

  assign col = pos_x ? (cx + xo) : (cx - xo);
  assign lo  = pos_y ? (cy + a) : (cy - b);
  assign hi  = pos_y ? (cy + b) : (cy - a);

  assign vis  = (col >= 0) && (col < w) && (hi >= 0) && (lo < h) && (lo <= hi);
  assign lo_c = (lo < 0) ? '0 : lo;
  assign hi_c = (hi > h - 1) ? (h - 1) : hi;

  always_comb begin
    span_o.visible     = vis;
    span_o.span_column = vis ? col[CoordW-1:0] : '0;
    span_o.row_first   = vis ? lo_c[CoordW-1:0] : '0;
    span_o.row_last    = vis ? hi_c[CoordW-1:0] : '0;
  end

endmodule

`default_nettype wire

[rtl/core/circle_span_rasterizer.sv]
// circle rasterizer that turns a circle into clipped vertical spans
// input words: opcode start latches centre, radius, fill mode and colour and
//   returns one status word; opcode step handles the next column offset and
//   returns four span words, one per quadrant, the last flagged last_of_step
// output words are held in one register; in_stall_o is low only when no
//   step is in work and that register is empty or being taken this cycle
// a step without an active circle returns one no-circle status word; start and
//   such a step give their word in the cycle after acceptance
// a step runs one shared 12x12 multiplier twice (r*r, then x*x) and a binary
//   digit-by-digit square root for 12 iterations, then issues the four spans one
//   per cycle while out_stall_i does not hold the output word; no new input word
//   is taken until the last span word has been issued, nor while out_stall_i
//   holds an output word
// a stalled output word stays unchanged until taken; the sequencer waits
// config writes go through cfg_valid_i / cfg_ready_o, always ready; index 0
//   is canvas width, 1 canvas height; canvas values above 4096 count as 4096
// reset: canvas 640 x 480, no active circle, output register empty
`default_nettype none

module circle_span_rasterizer (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire crast_pkg::in_word_t      in_word_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output crast_pkg::out_word_t          out_word_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_index_i,
  input  wire logic [crast_pkg::DimW-1:0] cfg_data_i
);
  import crast_pkg::*;

  localparam logic [1:0] TopIdle = 2'd0;
  localparam logic [1:0] TopRoot = 2'd1;
  localparam logic [1:0] TopEmit = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [DimW-1:0]   width_q, height_q;
  logic              active_q, active_d;
  logic              fill_q, fill_d;
  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d, rad_q, rad_d;
  logic [DimW-1:0]   col_off_q, col_off_d;
  logic [CoordW-1:0] prev_q, prev_d;
  logic [23:0]       color_q, color_d;
  logic [CoordW-1:0] near_q, near_d, far_q, far_d;
  logic              done_q, done_d;
  logic [1:0]        quad_q, quad_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              out_free, accept, sq_start, sq_done;
  logic [CoordW-1:0] sq_root, prev_eff;
  logic [DimW-1:0]   dim_w, dim_h;
  logic [1:0]        st;
  span_t             span;

  assign dim_w       = dim_clamp(width_q);
  assign dim_h       = dim_clamp(height_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != TopIdle) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign sq_start = accept && (in_word_i.opcode == OpStep) && active_q;

  crast_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sq_start),
    .radius_i (rad_q),
    .offset_i (col_off_q),
    .done_o   (sq_done),
    .root_o   (sq_root)
  );

  crast_span u_span (
    .center_x_i (cx_q),
    .center_y_i (cy_q),
    .offset_i   (col_off_q),
    .near_i     (near_q),
    .far_i      (far_q),
    .quad_i     (quad_q),
    .width_i    (dim_w),
    .height_i   (dim_h),
    .span_o     (span)
  );

  always_comb begin
    if ({1'b0, in_word_i.center_x} >= dim_w) begin
      st = StBadX;
    end else if ({1'b0, in_word_i.center_y} >= dim_h) begin
      st = StBadY;
    end else begin
      st = StOk;
    end
  end

  assign prev_eff = ((col_off_q == '0) || (prev_q < sq_root)) ? sq_root : prev_q;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    fill_d      = fill_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    rad_d       = rad_q;
    col_off_d   = col_off_q;
    prev_d      = prev_q;
    color_d     = color_q;
    near_d      = near_q;
    far_d       = far_q;
    done_d      = done_q;
    quad_d      = quad_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      TopIdle: begin
        if (accept) begin
          if (in_word_i.opcode == OpStart) begin
            cx_d      = in_word_i.center_x;
            cy_d      = in_word_i.center_y;
            rad_d     = in_word_i.radius;
            fill_d    = in_word_i.filled;
            color_d   = {in_word_i.color_red, in_word_i.color_green,
                         in_word_i.color_blue};
            col_off_d = '0;
            prev_d    = '0;
            active_d  = (st == StOk);
            out_d              = '0;
            out_d.status       = st;
            out_d.last_of_step = 1'b1;
            out_valid_d        = 1'b1;
          end else if (!active_q) begin
            out_d              = '0;
            out_d.status       = StNoCircle;
            out_d.last_of_step = 1'b1;
            out_valid_d        = 1'b1;
          end else begin
            state_d = TopRoot;
          end
        end
      end
      TopRoot: begin
        if (sq_done) begin
          near_d  = fill_q ? '0 : sq_root;
          far_d   = fill_q ? sq_root : prev_eff;
          done_d  = col_off_q >= {1'b0, rad_q};
          prev_d  = sq_root;
          quad_d  = QuadPosPos;
          state_d = TopEmit;
        end
      end
      TopEmit: begin
        if (out_free) begin
          out_d.status       = StOk;
          out_d.span_column  = span.span_column;
          out_d.row_first    = span.row_first;
          out_d.row_last     = span.row_last;
          out_d.visible      = span.visible;
          out_d.pixel_red    = color_q[23:16];
          out_d.pixel_green  = color_q[15:8];
          out_d.pixel_blue   = color_q[7:0];
          out_d.last_of_step = (quad_q == QuadPosNeg);
          out_d.drawing_done = done_q;
          out_valid_d        = 1'b1;
          quad_d             = quad_q + 2'd1;
          if (quad_q == QuadPosNeg) begin
            col_off_d = col_off_q + DimW'(1);
            if (done_q) begin
              active_d = 1'b0;
            end
            state_d = TopIdle;
          end
        end
      end
      default: state_d = TopIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TopIdle;
      width_q     <= 13'd640;
      height_q    <= 13'd480;
      active_q    <= 1'b0;
      fill_q      <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      rad_q       <= '0;
      col_off_q   <= '0;
      prev_q      <= '0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      fill_q      <= fill_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      rad_q       <= rad_d;
      col_off_q   <= col_off_d;
      prev_q      <= prev_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegCanvasWidth:  width_q  <= cfg_data_i;
          RegCanvasHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    near_q <= near_d;
    far_q  <= far_d;
    done_q <= done_d;
    quad_q <= quad_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire
